### hdl/tpd_pkg.sv
// shared constants and types for the trade profit block
package tpd_pkg;

    localparam int PRICE_W        = 16;
    localparam int PROFIT_W       = 22;
    localparam int MAX_DAYS_DEF   = 64;
    localparam int PRICE_BITS_DEF = 16;
    localparam logic [PROFIT_W-1:0] PROFIT_MAX = 22'd4194303;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PRIME,
        ST_BUY,
        ST_SELL,
        ST_EMIT
    } state_t;

endpackage

### hdl/tpd_if.sv
// valid/ready channels for price items and profit results
interface tpd_in_if import tpd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;
    logic               last_day;

    modport source (output valid, output price, output last_day, input ready);
    modport sink   (input valid, input price, input last_day, output ready);
endinterface

interface tpd_out_if import tpd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [PROFIT_W-1:0] best_profit;
    logic                too_long;

    modport source (output valid, output best_profit, output too_long, input ready);
    modport sink   (input valid, input best_profit, input too_long, output ready);
endinterface

### hdl/trade_profit_dp.sv
// best buy/sell profit over a price sequence, one shared add/compare unit
//
// days channel: one transfer per daily price; last_day marks the end of a
// sequence. result channel: one transfer per sequence, on its last day,
// with best_profit (profit ending with nothing held) and too_long.
// Each day sweeps the holding-count cells held in a small memory, cell by
// cell, through a buy candidate state then a sell candidate state in one
// add/compare unit. A day runs through fetch and prime, then the sweep, and
// then back to idle; a day past the limit is taken with no sweep at all.
// Days are taken one at a time; ready is high only between days.
// The result sits in an output register, so the next sequence starts while
// it waits; a further last day holds until that register is taken.
// Reset (rst_n low, asynchronous) empties the pipeline and marks every
// cell as fresh; fresh cells read as zero profit at holding zero and
// unreachable elsewhere, so no clearing pass is needed. Every cell is made
// fresh again in the same cycle that each result is loaded.
module trade_profit_dp import tpd_pkg::*; #(
    parameter int MAX_DAYS   = MAX_DAYS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tpd_in_if.sink    days,
    tpd_out_if.source result
);

    localparam int CELLS   = MAX_DAYS / 2 + 1;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(MAX_DAYS + 1);
    localparam int VAL_RAW = PRICE_BITS + $clog2(MAX_DAYS) + 2;
    localparam int VAL_W   = (VAL_RAW > 24) ? VAL_RAW : 24;

    state_t state_reg, state_next;

    logic [PRICE_BITS-1:0]   price_reg;
    logic                    last_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [CNT_W-1:0]        day_cnt_reg;
    logic                    ovf_reg;
    logic [CELLS-1:0]        valid_reg;
    logic                    out_vld_reg;
    logic [PROFIT_W-1:0]     profit_reg;
    logic                    too_long_reg;

    // cell word: {reachable, signed profit}
    logic [VAL_W:0]          mem [CELLS];
    logic [VAL_W:0]          rd_data_reg;
    logic                    rd_vld_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic [ADDR_W-1:0]       rd_addr;

    logic signed [VAL_W-1:0] prev_val_reg, cur_val_reg, acc_val_reg, res_val_reg;
    logic                    prev_rch_reg, cur_rch_reg, acc_rch_reg, res_rch_reg;

    logic                    in_ready;
    logic                    accept;
    logic                    too_many;
    logic                    out_free;
    logic                    wr_en;
    logic                    emit_go;
    logic                    at_top;
    logic [ADDR_W:0]         idx_inc;
    logic                    nb_in_range;

    logic signed [VAL_W-1:0] rd_val;
    logic                    rd_rch;
    logic signed [VAL_W-1:0] p_ext;
    logic signed [VAL_W-1:0] alu_a, alu_base, alu_sum, alu_res;
    logic                    alu_a_rch, alu_base_rch, alu_take, alu_res_rch;
    logic                    alu_sub;
    logic [PROFIT_W-1:0]     sat_profit;

    assign accept   = days.valid && in_ready;
    assign too_many = ovf_reg || (day_cnt_reg >= CNT_W'(MAX_DAYS));
    assign out_free = !out_vld_reg || result.ready;
    assign at_top   = (idx_reg == ADDR_W'(CELLS - 1));
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign nb_in_range = (idx_inc < (ADDR_W + 1)'(CELLS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!too_many)
                        state_next = ST_FETCH;
                    else if (days.last_day)
                        state_next = ST_EMIT;
                end
            end
            ST_FETCH: state_next = ST_PRIME;
            ST_PRIME: state_next = ST_BUY;
            ST_BUY:   state_next = ST_SELL;
            ST_SELL:
            begin
                if (!at_top)
                    state_next = ST_BUY;
                else if (last_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        emit_go  = 1'b0;
        alu_sub  = 1'b0;
        rd_addr  = nb_in_range ? idx_inc[ADDR_W-1:0] : '0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_FETCH: rd_addr  = '0;
            ST_PRIME: ;
            ST_BUY:   alu_sub  = 1'b1;
            ST_SELL:  wr_en    = 1'b1;
            ST_EMIT:  emit_go  = out_free;
            default:  ;
        endcase
    end

    assign days.ready = in_ready;

    // fresh cells read as the cleared value
    always_comb
    begin
        if (rd_vld_reg)
        begin
            rd_val = rd_data_reg[VAL_W-1:0];
            rd_rch = rd_data_reg[VAL_W];
        end
        else
        begin
            rd_val = '0;
            rd_rch = (rd_addr_reg == '0);
        end
    end

    // shared add/compare: buy pass uses the lower neighbor, sell pass the upper one
    assign p_ext        = VAL_W'(price_reg);
    assign alu_a        = alu_sub ? prev_val_reg : rd_val;
    assign alu_a_rch    = alu_sub ? prev_rch_reg : (rd_rch && nb_in_range);
    assign alu_base     = alu_sub ? cur_val_reg : acc_val_reg;
    assign alu_base_rch = alu_sub ? cur_rch_reg : acc_rch_reg;
    assign alu_sum      = alu_sub ? (alu_a - p_ext) : (alu_a + p_ext);
    assign alu_take     = alu_a_rch && (!alu_base_rch || (alu_sum > alu_base));
    assign alu_res      = alu_take ? alu_sum : alu_base;
    assign alu_res_rch  = alu_take || alu_base_rch;

    always_comb
    begin
        if (!res_rch_reg || res_val_reg < 0)
            sat_profit = '0;
        else if (res_val_reg > VAL_W'(PROFIT_MAX))
            sat_profit = PROFIT_MAX;
        else
            sat_profit = res_val_reg[PROFIT_W-1:0];
    end

    // cell memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= {alu_res_rch, alu_res};
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            price_reg <= PRICE_BITS'(days.price);
            last_reg  <= days.last_day;
        end
        if (state_reg == ST_PRIME)
        begin
            prev_rch_reg <= 1'b0;
            prev_val_reg <= '0;
            cur_val_reg  <= rd_val;
            cur_rch_reg  <= rd_rch;
        end
        if (state_reg == ST_BUY)
        begin
            acc_val_reg <= alu_res;
            acc_rch_reg <= alu_res_rch;
        end
        if (state_reg == ST_SELL)
        begin
            prev_val_reg <= cur_val_reg;
            prev_rch_reg <= cur_rch_reg;
            cur_val_reg  <= rd_val;
            cur_rch_reg  <= rd_rch && nb_in_range;
            if (idx_reg == '0)
            begin
                res_val_reg <= alu_res;
                res_rch_reg <= alu_res_rch;
            end
        end
        if (emit_go)
        begin
            profit_reg   <= ovf_reg ? '0 : sat_profit;
            too_long_reg <= ovf_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            day_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && too_many)
                ovf_reg <= 1'b1;
            if (state_reg == ST_FETCH)
                idx_reg <= '0;
            if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
                if (at_top)
                    day_cnt_reg <= day_cnt_reg + 1'b1;
                else
                    idx_reg <= idx_inc[ADDR_W-1:0];
            end
            if (emit_go)
            begin
                out_vld_reg <= 1'b1;
                valid_reg   <= '0;
                day_cnt_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.best_profit = profit_reg;
    assign result.too_long    = too_long_reg;

    // a new result only comes out of the emit state
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared without emit");

    // loading a result wipes the sequence state
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (valid_reg == '0 && day_cnt_reg == '0 && !ovf_reg))
        else $error("state not cleared after result");

    // day counter never passes the limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        day_cnt_reg <= CNT_W'(MAX_DAYS))
        else $error("day counter past limit");

    // a sweep only runs for an in-range day
    a_sweep_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_FETCH) |-> !too_many)
        else $error("sweep started after overflow");

    // a sweep visits the top cell right before leaving
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SELL && state_next != ST_BUY) |-> at_top)
        else $error("sweep ended early");

endmodule

### test/tb_top.sv
// self-checking testbench for trade_profit_dp: directed days, random sequences, backpressure
module tb_top import tpd_pkg::*;;

    localparam int     HOLD_CELLS = MAX_DAYS_DEF / 2 + 1;
    localparam longint NEG_MARK   = -64'sd1000000000;
    localparam int     RAND_DAYS  = 1600;
    localparam int     PLAN_LEN   = 24;
    localparam int     DRAIN_CYC  = 100;
    localparam int     HOLD_OFF   = 5000;

    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic                too_long;
    } profit_t;

    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic                last;
        logic                fixed;
        logic [PROFIT_W-1:0] profit;
        logic                too_long;
    } day_row_t;

    // fixed rows carry a hand-derived result, the rest go through the predictor
    localparam day_row_t DAY_PLAN [PLAN_LEN] = '{
        '{16'd0,     1'b1, 1'b1, 22'd0,     1'b0},
        '{16'd65535, 1'b1, 1'b1, 22'd0,     1'b0},
        '{16'd0,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd65535, 1'b1, 1'b1, 22'd65535, 1'b0},
        '{16'd65535, 1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd0,     1'b1, 1'b1, 22'd0,     1'b0},
        '{16'd100,   1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd40,    1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd90,    1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd10,    1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd70,    1'b1, 1'b0, 22'd0,     1'b0},
        '{16'd5,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd5,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd5,     1'b1, 1'b1, 22'd0,     1'b0},
        '{16'd65535, 1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd0,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd65535, 1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd0,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd65535, 1'b1, 1'b0, 22'd0,     1'b0},
        '{16'd1,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd2,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd4,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd8,     1'b0, 1'b0, 22'd0,     1'b0},
        '{16'd16,    1'b1, 1'b0, 22'd0,     1'b0}
    };

    logic clk;
    logic rst_n;

    tpd_in_if  days_if ();
    tpd_out_if result_if ();

    trade_profit_dp u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .days   (days_if),
        .result (result_if)
    );

    // predictor state
    longint      profit_cells [HOLD_CELLS];
    int unsigned days_in_seq;
    bit          seq_overflow;

    profit_t     profit_q [$];
    int          days_sent        = 0;
    int          results_seen     = 0;
    int          overflow_results = 0;
    int          sequences_sent   = 0;
    int          errors           = 0;
    bit          hold_off_done    = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic void clear_book();
        for (int h = 0; h < HOLD_CELLS; h++)
            profit_cells[h] = NEG_MARK;
        profit_cells[0] = 0;
        days_in_seq  = 0;
        seq_overflow = 1'b0;
    endfunction

    function automatic void absorb_price(input longint p);
        longint nxt [HOLD_CELLS];
        longint best;
        longint cand;
        for (int h = 0; h < HOLD_CELLS; h++)
        begin
            best = profit_cells[h];
            if (h > 0 && profit_cells[h-1] != NEG_MARK)
            begin
                cand = profit_cells[h-1] - p;
                if (best == NEG_MARK || cand > best)
                    best = cand;
            end
            // buys past the top cell are dropped
            if (h + 1 < HOLD_CELLS && profit_cells[h+1] != NEG_MARK)
            begin
                cand = profit_cells[h+1] + p;
                if (best == NEG_MARK || cand > best)
                    best = cand;
            end
            nxt[h] = best;
        end
        profit_cells = nxt;
    endfunction

    function automatic void trade_day(input logic [PRICE_W-1:0] p, input logic last,
                                      output bit emits, output profit_t res);
        longint masked;
        longint r;
        masked = longint'(p) & ((64'sd1 << PRICE_BITS_DEF) - 1);
        emits  = 1'b0;
        res    = '0;
        if (seq_overflow || days_in_seq >= MAX_DAYS_DEF)
        begin
            seq_overflow = 1'b1;
        end
        else
        begin
            absorb_price(masked);
            days_in_seq++;
        end
        if (last)
        begin
            emits = 1'b1;
            if (seq_overflow)
            begin
                res.profit   = '0;
                res.too_long = 1'b1;
            end
            else
            begin
                r = profit_cells[0];
                if (r < 0)
                    r = 0;
                if (r > longint'(PROFIT_MAX))
                    r = longint'(PROFIT_MAX);
                res.profit   = r[PROFIT_W-1:0];
                res.too_long = 1'b0;
            end
            clear_book();
        end
    endfunction

    task automatic flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic send_day(input logic [PRICE_W-1:0] p, input logic last,
                            input bit fixed, input profit_t fixed_res);
        int      gap;
        bit      emits;
        profit_t res;
        // every fifth window of days runs back to back
        gap = ((days_sent / 150) % 5 == 4) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            days_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        days_if.valid    <= 1'b1;
        days_if.price    <= p;
        days_if.last_day <= last;
        @(posedge clk);
        while (!days_if.ready)
            @(posedge clk);
        trade_day(p, last, emits, res);
        if (emits)
            profit_q.push_back(fixed ? fixed_res : res);
        days_sent++;
        if (last)
            sequences_sent++;
    endtask

    function automatic logic [PRICE_W-1:0] draw_price(input int style, input int base);
        case (style)
            0:       return PRICE_W'($urandom());
            1:       return PRICE_W'(base + $urandom_range(0, 15));
            2:       return $urandom_range(0, 1) ? {PRICE_W{1'b1}} : '0;
            default: return PRICE_W'($urandom_range(65520, 65535));
        endcase
    endfunction

    function automatic int draw_length(input int seq_no);
        int r;
        // open with the day limit exactly, one past it, and well past it
        if (seq_no == 0)
            return MAX_DAYS_DEF;
        if (seq_no == 1)
            return MAX_DAYS_DEF + 1;
        if (seq_no == 2)
            return MAX_DAYS_DEF + 6;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 8);
        if (r < 75)
            return $urandom_range(9, 32);
        if (r < 85)
            return $urandom_range(33, MAX_DAYS_DEF - 1);
        if (r < 90)
            return MAX_DAYS_DEF;
        if (r < 95)
            return MAX_DAYS_DEF + 1;
        return $urandom_range(MAX_DAYS_DEF + 2, MAX_DAYS_DEF + 16);
    endfunction

    // result side: random stalls, one long hold-off so the block backs up
    initial
    begin
        int      stall;
        profit_t got;
        profit_t want;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ((results_seen / 10) % 4 == 3) ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            if (!hold_off_done && results_seen == 12)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_off_done = 1'b1;
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
            got.profit   = result_if.best_profit;
            got.too_long = result_if.too_long;
            results_seen++;
            if (got.too_long)
                overflow_results++;
            if (profit_q.size() == 0)
            begin
                flag($sformatf("result with nothing pending: profit=%0d too_long=%0b",
                               got.profit, got.too_long));
            end
            else
            begin
                want = profit_q.pop_front();
                if (got.profit !== want.profit || got.too_long !== want.too_long)
                    flag($sformatf({"expected profit=%0d too_long=%0b, ",
                                    "got profit=%0d too_long=%0b"},
                                   want.profit, want.too_long, got.profit, got.too_long));
            end
        end
    end

    // day side and run control
    initial
    begin
        int seq_no;
        int seq_len;
        int style;
        int base;
        int rand_days;
        days_if.valid    <= 1'b0;
        days_if.price    <= '0;
        days_if.last_day <= 1'b0;
        rst_n            <= 1'b0;
        clear_book();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
            send_day(DAY_PLAN[i].price, DAY_PLAN[i].last, DAY_PLAN[i].fixed,
                     '{DAY_PLAN[i].profit, DAY_PLAN[i].too_long});

        seq_no    = 0;
        rand_days = 0;
        while (rand_days < RAND_DAYS)
        begin
            seq_len = draw_length(seq_no);
            style   = $urandom_range(0, 3);
            base    = $urandom_range(0, 65520);
            for (int d = 0; d < seq_len; d++)
                send_day(draw_price(style, base), d == seq_len - 1, 1'b0, '0);
            rand_days += seq_len;
            seq_no++;
        end
        days_if.valid <= 1'b0;

        while (profit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("run covered %0d days in %0d sequences, %0d results (%0d over the day limit)",
                 days_sent, sequences_sent, results_seen, overflow_results);
        $display("mismatches: %0d, long result hold-off done: %0b", errors, hold_off_done);
        if (errors == 0 && profit_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d results still pending", profit_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
